// ----- sv/smf_pkg.sv -----
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types and codes for the track event parser.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam logic [15:0] TPQ_RESET = 16'd480;
  localparam logic [31:0] TEMPO_RESET = 32'd10000;
  localparam logic [6:0] TEXT_INIT = 7'h60;

  localparam logic [2:0] EV_CHAN   = 3'd0;
  localparam logic [2:0] EV_SYSHDR = 3'd1;
  localparam logic [2:0] EV_SYSBYT = 3'd2;
  localparam logic [2:0] EV_TEMPO  = 3'd3;
  localparam logic [2:0] EV_MEAS   = 3'd4;
  localparam logic [2:0] EV_LOOP   = 3'd5;
  localparam logic [2:0] EV_END    = 3'd6;

  localparam logic [7:0] ST_SYSEX = 8'hF0;
  localparam logic [7:0] ST_META  = 8'hFF;
  localparam logic [7:0] MC_TEXT  = 8'h01;
  localparam logic [7:0] MC_CUE   = 8'h07;
  localparam logic [7:0] MC_END   = 8'h2F;
  localparam logic [7:0] MC_TEMPO = 8'h51;
  localparam logic [7:0] MC_TSIG  = 8'h58;
  localparam logic [7:0] MC_LOOP  = 8'h7F;

  // Result word, highest field first as on the output bus.
  typedef struct packed {
    logic signed [13:0] bend_offset;
    logic [31:0] event_value;
    logic [6:0]  second_data;
    logic [6:0]  first_data;
    logic [7:0]  status_byte;
    logic [27:0] delta_ticks;
    logic [2:0]  event_kind;
  } result_t;

  // Classified word handed from front to back: measure needs a multiply.
  typedef struct packed {
    logic        is_meas;
    logic [7:0]  nn;
    logic [7:0]  dd;
    result_t     res;
  } work_t;

  function automatic logic [7:0] fold(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
  endfunction

  function automatic logic [7:0] kw_long(input logic [4:0] i);
    case (i)
      5'd0: return "x";  5'd1: return "a";  5'd2: return "_";  5'd3: return "m";
      5'd4: return "i";  5'd5: return "d";  5'd6: return "i";  5'd7: return "_";
      5'd8: return "c";  5'd9: return "t";  5'd10: return "l"; 5'd11: return ".";
      5'd12: return "l"; 5'd13: return "o"; 5'd14: return "o"; 5'd15: return "p";
      5'd16: return "_"; 5'd17: return "a"; 5'd18: return "t";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] kw_short(input logic [4:0] i);
    case (i)
      5'd0: return "l"; 5'd1: return "o"; 5'd2: return "o"; 5'd3: return "p";
      default: return 8'h00;
    endcase
  endfunction

endpackage

// ----- sv/smf_front.sv -----
// ----------------------------------------------------------------------------
// smf_front
// Byte parser: walks the track grammar and classifies at most one result per byte.
// ----------------------------------------------------------------------------
module smf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_vld,
  input  logic [7:0]         data_byte,
  input  logic               track_start,
  output logic               work_vld,
  output smf_pkg::work_t     work
);

  typedef enum logic [3:0] {
    PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_ONE, PH_SYSLEN, PH_SYSBODY,
    PH_MCODE, PH_MLEN, PH_TEMPO, PH_TSIG, PH_TEXT, PH_SKIP
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  rs_r, rs_nxt;
  logic [31:0] nacc_r, nacc_nxt;
  logic [27:0] pdel_r, pdel_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  mcode_r, mcode_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] tempo_r, tempo_nxt;
  logic [31:0] vacc_r, vacc_nxt;
  logic [6:0]  tm_r, tm_nxt;
  logic        ended_r, ended_nxt;

  function automatic phase_t phase_after(input logic [7:0] st);
    logic [3:0] hi;
    hi = st[7:4];
    case (hi)
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: return PH_DATA1;
      4'hC, 4'hD: return PH_ONE;
      default: begin
        if (st == smf_pkg::ST_SYSEX) return PH_SYSLEN;
        if (st == smf_pkg::ST_META) return PH_MCODE;
        return PH_DELTA;
      end
    endcase
  endfunction

  always_comb begin
    logic [7:0]  rs;
    logic [31:0] nacc, vlq, size, rem1, tv;
    logic [27:0] pdel;
    logic [4:0]  idx;
    logic        a, s;
    phase_t      ph;
    phase_nxt = phase_r; rs_nxt = rs_r; nacc_nxt = nacc_r; pdel_nxt = pdel_r;
    held_nxt = held_r; mcode_nxt = mcode_r; rem_nxt = rem_r; tempo_nxt = tempo_r;
    vacc_nxt = vacc_r; tm_nxt = tm_r; ended_nxt = ended_r;
    work_vld = 1'b0;
    work = '0;
    rs = rs_r; nacc = nacc_r; pdel = pdel_r; ph = phase_r;
    if (track_start) begin
      rs = '0; ph = PH_DELTA; nacc = '0; pdel = '0;
    end
    vlq = {nacc[24:0], data_byte[6:0]};
    rem1 = rem_r - 32'd1;
    idx = tm_r[4:0];
    a = 1'b0; s = 1'b0; size = '0; tv = '0;
    if (byte_vld) begin
      rs_nxt = rs; nacc_nxt = nacc; pdel_nxt = pdel; phase_nxt = ph;
      if (track_start) ended_nxt = 1'b0;
      // Data byte where status is expected: resolve running status first.
      if (ph == PH_STATUS && !data_byte[7]) begin
        ph = phase_after(rs);
        nacc_nxt = '0;
        phase_nxt = ph;
      end
      work.res.delta_ticks = pdel;
      work.res.status_byte = smf_pkg::ST_META;
      if (!(ended_r && !track_start)) begin
        unique case (ph)
          PH_DELTA: begin
            nacc_nxt = vlq;
            if (!data_byte[7]) begin
              pdel_nxt = vlq[27:0]; nacc_nxt = '0; phase_nxt = PH_STATUS;
            end
          end
          PH_STATUS: begin
            rs_nxt = data_byte; phase_nxt = phase_after(data_byte); nacc_nxt = '0;
          end
          PH_DATA1: begin
            held_nxt = data_byte; phase_nxt = PH_DATA2;
          end
          PH_DATA2: begin
            phase_nxt = PH_DELTA; work_vld = 1'b1;
            work.res.event_kind = smf_pkg::EV_CHAN;
            work.res.status_byte = rs;
            work.res.first_data = held_r[6:0];
            work.res.second_data = data_byte[6:0];
            if (rs[7:4] == 4'hE)
              work.res.bend_offset = $signed({data_byte[6:0], held_r[6:0]} - 14'h2000);
          end
          PH_ONE: begin
            phase_nxt = PH_DELTA; work_vld = 1'b1;
            work.res.event_kind = smf_pkg::EV_CHAN;
            work.res.status_byte = rs;
            work.res.first_data = data_byte[6:0];
          end
          PH_SYSLEN: begin
            nacc_nxt = vlq;
            if (!data_byte[7]) begin
              size = vlq + 32'd1;
              rem_nxt = (size == '0) ? '0 : vlq;
              nacc_nxt = '0;
              phase_nxt = (size == '0 || vlq == '0) ? PH_DELTA : PH_SYSBODY;
              work_vld = 1'b1;
              work.res.event_kind = smf_pkg::EV_SYSHDR;
              work.res.status_byte = smf_pkg::ST_SYSEX;
              work.res.event_value = size;
            end
          end
          PH_SYSBODY: begin
            rem_nxt = rem1;
            if (rem1 == '0) phase_nxt = PH_DELTA;
            work_vld = 1'b1;
            work.res.event_kind = smf_pkg::EV_SYSBYT;
            work.res.delta_ticks = '0;
            work.res.status_byte = smf_pkg::ST_SYSEX;
            work.res.event_value = {24'd0, data_byte};
          end
          PH_MCODE: begin
            mcode_nxt = data_byte; nacc_nxt = '0; phase_nxt = PH_MLEN;
          end
          PH_MLEN: begin
            nacc_nxt = vlq;
            if (!data_byte[7]) begin
              rem_nxt = vlq; nacc_nxt = '0;
              work.res.event_kind = smf_pkg::EV_LOOP;
              if (mcode_r == smf_pkg::MC_END) begin
                ended_nxt = 1'b1; phase_nxt = PH_DELTA; work_vld = 1'b1;
                work.res.event_kind = smf_pkg::EV_END;
              end else if (mcode_r == smf_pkg::MC_TEMPO) begin
                vacc_nxt = '0;
                if (vlq == '0) begin
                  phase_nxt = PH_DELTA;
                  if (tempo_r != '0) begin
                    tempo_nxt = '0; work_vld = 1'b1;
                    work.res.event_kind = smf_pkg::EV_TEMPO;
                  end
                end else phase_nxt = PH_TEMPO;
              end else if (mcode_r == smf_pkg::MC_TSIG && vlq == 32'd4) begin
                phase_nxt = PH_TSIG;
              end else if (mcode_r == smf_pkg::MC_TEXT || mcode_r == smf_pkg::MC_CUE) begin
                tm_nxt = smf_pkg::TEXT_INIT;
                if (vlq == '0) begin
                  phase_nxt = PH_DELTA; work_vld = 1'b1;
                end else phase_nxt = PH_TEXT;
              end else begin
                phase_nxt = (vlq != '0) ? PH_SKIP : PH_DELTA;
                work_vld = (mcode_r == smf_pkg::MC_LOOP);
              end
            end
          end
          PH_TEMPO: begin
            tv = {vacc_r[23:0], data_byte};
            vacc_nxt = tv; rem_nxt = rem1;
            if (rem1 == '0) begin
              phase_nxt = PH_DELTA;
              if (tv != tempo_r) begin
                tempo_nxt = tv; work_vld = 1'b1;
                work.res.event_kind = smf_pkg::EV_TEMPO;
                work.res.event_value = tv;
              end
            end
          end
          PH_TSIG: begin
            if (rem_r == 32'd4) held_nxt = data_byte;
            if (rem_r == 32'd3) vacc_nxt = {24'd0, data_byte};
            rem_nxt = rem1;
            if (rem1 == '0) begin
              phase_nxt = PH_DELTA; work_vld = 1'b1;
              work.is_meas = 1'b1;
              work.nn = held_r;
              work.dd = vacc_r[7:0];
              if (vacc_r[31:8] != '0) work.dd = 8'hFF;
              work.res.event_kind = smf_pkg::EV_MEAS;
            end
          end
          PH_TEXT: begin
            if (tm_r[6])
              a = (idx < 5'd19) ? (smf_pkg::fold(data_byte) == smf_pkg::kw_long(idx)) :
                  (idx == 5'd19) ? (data_byte == 8'h00) : 1'b1;
            if (tm_r[5])
              s = (idx < 5'd4) ? (smf_pkg::fold(data_byte) == smf_pkg::kw_short(idx)) :
                  (idx == 5'd4) ? (data_byte == 8'h00) : 1'b1;
            tm_nxt = {a, s, (idx == 5'd31) ? idx : idx + 5'd1};
            rem_nxt = rem1;
            if (rem1 == '0) begin
              phase_nxt = PH_DELTA;
              work_vld = a | s;
              work.res.event_kind = smf_pkg::EV_LOOP;
            end
          end
          PH_SKIP: begin
            rem_nxt = rem1;
            if (rem1 == '0) phase_nxt = PH_DELTA;
          end
          default: phase_nxt = PH_DELTA;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA; rs_r <= '0; nacc_r <= '0; pdel_r <= '0; held_r <= '0;
      mcode_r <= '0; rem_r <= '0; tempo_r <= smf_pkg::TEMPO_RESET; vacc_r <= '0;
      tm_r <= smf_pkg::TEXT_INIT; ended_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; rs_r <= rs_nxt; nacc_r <= nacc_nxt; pdel_r <= pdel_nxt;
      held_r <= held_nxt; mcode_r <= mcode_nxt; rem_r <= rem_nxt; tempo_r <= tempo_nxt;
      vacc_r <= vacc_nxt; tm_r <= tm_nxt; ended_r <= ended_nxt;
    end
  end

endmodule

// ----- sv/smf_queue.sv -----
// ----------------------------------------------------------------------------
// smf_queue
// Short FIFO between parser and executor.
// ----------------------------------------------------------------------------
module smf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  smf_pkg::work_t push_data,
  input  logic           pop,
  output logic           nonempty,
  output logic           full,
  output smf_pkg::work_t head
);

  localparam int unsigned AW = $clog2(smf_pkg::QDEPTH);
  smf_pkg::work_t mem_r [smf_pkg::QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign nonempty = (cnt_r != '0);
  assign full = (cnt_r == (AW+1)'(smf_pkg::QDEPTH));
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + AW'(1);
      if (pop) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ----- sv/smf_back.sv -----
// ----------------------------------------------------------------------------
// smf_back
// Executor: computes measure length and holds the output register.
// ----------------------------------------------------------------------------
module smf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [15:0]       tpq,
  input  logic              q_vld,
  input  smf_pkg::work_t    q_head,
  output logic              q_pop,
  output logic              out_vld,
  input  logic              out_rdy,
  output smf_pkg::result_t  out_res
);

  // Stage 1: multiply; stage 2: shift into output register.
  logic             s1_vld_r;
  smf_pkg::work_t   s1_r;
  logic [31:0]      prod_r;
  logic             o_vld_r;
  smf_pkg::result_t o_r, o_nxt;
  logic             o_free, s1_adv;
  logic [31:0]      len;

  assign o_free = !o_vld_r || out_rdy;
  assign s1_adv = s1_vld_r && o_free;
  assign q_pop = q_vld && (!s1_vld_r || o_free);
  assign out_vld = o_vld_r;
  assign out_res = o_r;
  assign len = (s1_r.dd < 8'd32) ? (prod_r >> s1_r.dd[4:0]) : '0;

  always_comb begin
    o_nxt = s1_r.res;
    if (s1_r.is_meas) o_nxt.event_value = len;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_r <= q_head;
      prod_r <= {14'd0, tpq, 2'b00} * {24'd0, q_head.nn};
    end
    if (s1_adv) o_r <= o_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0; o_vld_r <= 1'b0;
    end else begin
      if (q_pop) s1_vld_r <= 1'b1;
      else if (s1_adv) s1_vld_r <= 1'b0;
      if (s1_adv) o_vld_r <= 1'b1;
      else if (out_rdy) o_vld_r <= 1'b0;
    end
  end

endmodule

// ----- sv/smf_track_event_parser_core.sv -----
// ----------------------------------------------------------------------------
// smf_track_event_parser_core
// Standard MIDI file track body parser with decoupled decode and output.
// ----------------------------------------------------------------------------
// One track byte is taken per cycle while in_tready is high; each byte gives zero or one
// result word. After its byte is accepted, a result word passes through the parser
// register, the queue entry, the multiply stage and the output register in that order,
// and can wait where the output stalls. The parser always runs: in_tready drops only
// when the two-entry queue could not absorb a further result, which the queue count
// and the pending stage set.
module smf_track_event_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,     // ticks_per_quarter
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // data_byte
  input  logic        in_tuser,      // track_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,     // delta_ticks, status_byte, first_data,
                                     // second_data, event_value, bend_offset
  output logic [2:0]  out_tuser      // event_kind
);

  logic [15:0]      tpq_r;
  logic             w_vld, w_vld_r, q_ne, q_full, q_pop;
  smf_pkg::work_t   w, w_r, q_head;
  smf_pkg::result_t res;

  // Hold the timebase register.
  always_ff @(posedge clk) begin
    if (!rst_n) tpq_r <= smf_pkg::TPQ_RESET;
    else if (cfg_we) tpq_r <= cfg_wdata;
  end

  // Accept only while the registered word is sure to find queue room.
  assign in_tready = !q_full && !(w_vld_r && q_ne && !q_pop);

  smf_front u_front (
    .clk(clk), .rst_n(rst_n), .byte_vld(in_tvalid && in_tready),
    .data_byte(in_tdata), .track_start(in_tuser), .work_vld(w_vld), .work(w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) w_vld_r <= 1'b0;
    else w_vld_r <= w_vld;
    w_r <= w;
  end

  smf_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(w_vld_r), .push_data(w_r), .pop(q_pop),
    .nonempty(q_ne), .full(q_full), .head(q_head)
  );

  smf_back u_back (
    .clk(clk), .rst_n(rst_n), .tpq(tpq_r), .q_vld(q_ne), .q_head(q_head),
    .q_pop(q_pop), .out_vld(out_tvalid), .out_rdy(out_tready), .out_res(res)
  );

  assign out_tdata = {res.bend_offset, res.event_value, res.second_data,
                      res.first_data, res.status_byte, res.delta_ticks};
  assign out_tuser = res.event_kind;

endmodule

// ----- tb/sv/smf_track_event_parser_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_track_event_parser_core_tb
// Feeds well-formed track bodies with random content (channel messages,
// running status, sysex, tempo, time signature, text, loop and end events)
// plus noise bytes, predicts each decoded event in-line and checks every
// output word field by field. Idling on both sides varies by phase, and the
// timebase register is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module smf_track_event_parser_core_tb;
  import smf_pkg::*;

  // Parse phases of the tracking predictor.
  localparam logic [3:0] P_DELTA = 4'd0, P_STATUS = 4'd1, P_DATA1 = 4'd2,
                         P_DATA2 = 4'd3, P_ONE = 4'd4, P_SYSLEN = 4'd5,
                         P_SYSBODY = 4'd6, P_MCODE = 4'd7, P_MLEN = 4'd8,
                         P_TEMPO = 4'd9, P_TSIG = 4'd10, P_TEXT = 4'd11,
                         P_SKIP = 4'd12;
  localparam int WATCH_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [7:0] b;
    logic       start;
  } byte_word_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // data_byte
  logic        in_tuser;    // track_start
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;   // delta_ticks, status_byte, first_data,
                            // second_data, event_value, bend_offset
  logic [2:0]  out_tuser;   // event_kind

  smf_track_event_parser_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  byte_word_t byte_q[$];
  result_t    event_q[$];
  int         errors = 0;
  int         sender_idle_pct = 0;
  int         receiver_stall_pct = 0;
  bit         hold_arm = 0;
  int         hold_left = 0;
  bit         in_taken = 0;
  int         quiet_cycles = 0;

  // Predictor state.
  logic [15:0] tpq;
  logic [3:0]  phase;
  logic [7:0]  run_status;
  logic [31:0] num_acc;
  logic [27:0] delta_hold;
  logic [7:0]  held;
  logic [7:0]  mcode;
  logic [31:0] remaining;
  logic [31:0] tempo_now;
  logic [31:0] val_acc;
  logic [6:0]  text_state;
  logic        ended;
  string       key_long;
  string       key_upper;
  string       key_prefix;
  string       key_mixed;
  string       key_short = "loop";

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [7:0] lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
  endfunction

  function automatic logic [3:0] phase_for(input logic [7:0] st);
    case (st[7:4])
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: return P_DATA1;
      4'hC, 4'hD: return P_ONE;
      default: begin
        if (st == ST_SYSEX) return P_SYSLEN;
        if (st == ST_META) return P_MCODE;
        return P_DELTA;
      end
    endcase
  endfunction

  function automatic logic key_step(input logic alive, input string kw, input int idx,
                                    input logic [7:0] b);
    if (!alive) return 1'b0;
    if (idx < kw.len()) return lower(b) == kw[idx];
    if (idx == kw.len()) return b == 8'h00;
    return 1'b1;
  endfunction

  function automatic result_t make_event(input logic [2:0] kind, input logic [27:0] dt,
                                         input logic [7:0] st, input logic [31:0] val);
    result_t r;
    r = '0;
    r.event_kind = kind;
    r.delta_ticks = dt;
    r.status_byte = st;
    r.event_value = val;
    return r;
  endfunction

  task automatic reset_model();
    tpq = TPQ_RESET; phase = P_DELTA; run_status = 0; num_acc = 0; delta_hold = 0;
    held = 0; mcode = 0; remaining = 0; tempo_now = TEMPO_RESET; val_acc = 0;
    text_state = TEXT_INIT; ended = 0;
  endtask

  task automatic close_tempo();
    phase = P_DELTA;
    if (val_acc != tempo_now) begin
      tempo_now = val_acc;
      event_q.push_back(make_event(EV_TEMPO, delta_hold, ST_META, tempo_now));
    end
  endtask

  // Advance the parse state by one accepted byte and queue its event, if any.
  task automatic decode_byte(input logic [7:0] b, input logic start);
    result_t r;
    logic again;
    logic [31:0] mlen;
    logic [31:0] pos;
    int idx;
    logic a, s;
    if (start) begin
      run_status = 0; phase = P_DELTA; num_acc = 0; delta_hold = 0; ended = 0;
    end
    if (ended) return;
    again = 1;
    while (again) begin
      again = 0;
      case (phase)
        P_DELTA: begin
          num_acc = (num_acc << 7) + b[6:0];
          if (!b[7]) begin
            delta_hold = num_acc[27:0]; num_acc = 0; phase = P_STATUS;
          end
        end
        P_STATUS: begin
          num_acc = 0;
          if (b[7]) begin
            run_status = b; phase = phase_for(b);
          end else begin
            phase = phase_for(run_status); again = 1;   // running status
          end
        end
        P_DATA1: begin
          held = b; phase = P_DATA2;
        end
        P_DATA2: begin
          r = make_event(EV_CHAN, delta_hold, run_status, 0);
          r.first_data = held[6:0];
          r.second_data = b[6:0];
          if (run_status[7:4] == 4'hE) r.bend_offset = {b[6:0], held[6:0]} - 14'h2000;
          event_q.push_back(r);
          phase = P_DELTA;
        end
        P_ONE: begin
          r = make_event(EV_CHAN, delta_hold, run_status, 0);
          r.first_data = b[6:0];
          event_q.push_back(r);
          phase = P_DELTA;
        end
        P_SYSLEN: begin
          num_acc = (num_acc << 7) + b[6:0];
          if (!b[7]) begin
            remaining = (num_acc + 1 == 0) ? 32'd0 : num_acc;
            event_q.push_back(make_event(EV_SYSHDR, delta_hold, ST_SYSEX, num_acc + 1));
            num_acc = 0;
            phase = (remaining != 0) ? P_SYSBODY : P_DELTA;
          end
        end
        P_SYSBODY: begin
          remaining--;
          if (remaining == 0) phase = P_DELTA;
          event_q.push_back(make_event(EV_SYSBYT, 0, ST_SYSEX, {24'd0, b}));
        end
        P_MCODE: begin
          mcode = b; num_acc = 0; phase = P_MLEN;
        end
        P_MLEN: begin
          num_acc = (num_acc << 7) + b[6:0];
          if (!b[7]) begin
            remaining = num_acc; num_acc = 0;
            if (mcode == MC_END) begin
              ended = 1; phase = P_DELTA;
              event_q.push_back(make_event(EV_END, delta_hold, ST_META, 0));
            end else if (mcode == MC_TEMPO) begin
              val_acc = 0;
              if (remaining == 0) close_tempo();
              else phase = P_TEMPO;
            end else if (mcode == MC_TSIG && remaining == 4) begin
              phase = P_TSIG;
            end else if (mcode == MC_TEXT || mcode == MC_CUE) begin
              text_state = TEXT_INIT;
              if (remaining == 0) begin
                phase = P_DELTA;
                event_q.push_back(make_event(EV_LOOP, delta_hold, ST_META, 0));
              end else phase = P_TEXT;
            end else begin
              phase = (remaining != 0) ? P_SKIP : P_DELTA;
              if (mcode == MC_LOOP)
                event_q.push_back(make_event(EV_LOOP, delta_hold, ST_META, 0));
            end
          end
        end
        P_TEMPO: begin
          val_acc = (val_acc << 8) + b;
          remaining--;
          if (remaining == 0) close_tempo();
        end
        P_TSIG: begin
          pos = 4 - remaining;
          if (pos == 0) held = b;
          else if (pos == 1) val_acc = {24'd0, b};
          remaining--;
          if (remaining == 0) begin
            mlen = 32'd4 * tpq * held;
            mlen = (val_acc < 32) ? (mlen >> val_acc) : 32'd0;
            phase = P_DELTA;
            event_q.push_back(make_event(EV_MEAS, delta_hold, ST_META, mlen));
          end
        end
        P_TEXT: begin
          idx = text_state[4:0];
          a = key_step(text_state[6], key_long, idx, b);
          s = key_step(text_state[5], key_short, idx, b);
          if (idx < 31) idx++;
          text_state = {a, s, idx[4:0]};
          remaining--;
          if (remaining == 0) begin
            phase = P_DELTA;
            if (a | s) event_q.push_back(make_event(EV_LOOP, delta_hold, ST_META, 0));
          end
        end
        P_SKIP: begin
          remaining--;
          if (remaining == 0) phase = P_DELTA;
        end
        default: phase = P_DELTA;
      endcase
    end
  endtask

  // Input side: present a new word at the falling edge once the last one went.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (byte_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_tvalid <= 1'b1;
        {in_tdata, in_tuser} <= byte_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output side: random stalls, plus one long hold-off when armed.
  always @(negedge clk) begin
    if (hold_arm && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
      hold_arm <= 1'b0;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Sample handshakes, predict, check, and watch for a hang.
  always @(posedge clk) begin
    result_t got, want;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        got = {out_tdata, out_tuser};
        if (event_q.size() == 0) begin
          report("unexpected word kind", got.event_kind, 0);
        end else begin
          want = event_q.pop_front();
          if (got.event_kind != want.event_kind)
            report("event_kind", got.event_kind, want.event_kind);
          if (got.delta_ticks != want.delta_ticks)
            report("delta_ticks", got.delta_ticks, want.delta_ticks);
          if (got.status_byte != want.status_byte)
            report("status_byte", got.status_byte, want.status_byte);
          if (got.first_data != want.first_data)
            report("first_data", got.first_data, want.first_data);
          if (got.second_data != want.second_data)
            report("second_data", got.second_data, want.second_data);
          if (got.event_value != want.event_value)
            report("event_value", got.event_value, want.event_value);
          if (got.bend_offset != want.bend_offset)
            report("bend_offset", got.bend_offset, want.bend_offset);
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else if (hold_left == 0) quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---- stimulus builders ----
  task automatic put(input logic [7:0] b, input logic start = 0);
    byte_q.push_back({b, start});
  endtask

  task automatic put_vlq(input logic [31:0] v);
    logic [7:0] grp[$];
    grp.push_front({1'b0, v[6:0]});
    v = v >> 7;
    while (v != 0) begin
      grp.push_front({1'b1, v[6:0]});
      v = v >> 7;
    end
    foreach (grp[i]) put(grp[i]);
  endtask

  task automatic put_delta();
    case ($urandom_range(9))
      0: put_vlq($urandom);                  // large, may exceed 28 bits
      1, 2: put_vlq($urandom_range(16383));
      default: put_vlq($urandom_range(127));
    endcase
  endtask

  function automatic logic [7:0] data_byte();
    return ($urandom_range(15) == 0) ? 8'($urandom) : 8'($urandom_range(127));
  endfunction

  task automatic put_text(input string t);
    put(ST_META); put(($urandom_range(1)) ? MC_TEXT : MC_CUE); put_vlq(t.len());
    foreach (t[i]) put(t[i]);
  endtask

  task automatic put_event();
    logic [7:0] st;
    int n;
    logic [31:0] tv;
    string texts[10] = '{"loop", "LOOP", "Lo", "", key_upper, key_prefix,
                         "loopy", key_mixed, "nope", "lop"};
    put_delta();
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5: begin
        st = 8'h80 | 8'($urandom_range(111));   // 0x80..0xEF
        if ($urandom_range(3) != 0) put(st);    // otherwise rely on running status
        put(data_byte());
        if (st[7:4] != 4'hC && st[7:4] != 4'hD) put(data_byte());
      end
      6, 7: begin
        n = $urandom_range(5);
        put(ST_SYSEX); put_vlq(n);
        repeat (n) put(8'($urandom));
      end
      8, 9: begin
        n = $urandom_range(5);
        case ($urandom_range(3))
          0: tv = tempo_now;
          1: tv = 32'd500000;
          2: tv = 32'd10000;
          default: tv = $urandom;
        endcase
        put(ST_META); put(MC_TEMPO); put_vlq(n);
        for (int i = n - 1; i >= 0; i--) put((i < 4) ? tv[8*i +: 8] : 8'($urandom));
      end
      10, 11: begin
        n = ($urandom_range(4) == 0) ? $urandom_range(6) : 4;
        put(ST_META); put(MC_TSIG); put_vlq(n);
        put(8'($urandom_range(1) ? $urandom_range(16) : $urandom));
        if (n > 1) put(8'($urandom_range(3) ? $urandom_range(6) : $urandom));
        for (int i = 2; i < n; i++) put(8'($urandom));
      end
      12, 13: begin
        if ($urandom_range(3) == 0) begin
          put(ST_META); put(MC_TEXT); put(8'd7);
          put("l"); put("o"); put("o"); put("p"); put(8'h00); put("z"); put("q");
        end else put_text(texts[$urandom_range(9)]);
      end
      14: begin
        n = $urandom_range(3);
        put(ST_META); put(MC_LOOP); put_vlq(n);
        repeat (n) put(8'($urandom));
      end
      15: begin
        n = $urandom_range(3);
        put(ST_META); put(8'($urandom)); put_vlq(n);
        repeat (n) put(8'($urandom));
      end
      16: put(8'hF1 + 8'($urandom_range(13)));   // system status: no event
      17: repeat ($urandom_range(1, 4)) put(8'($urandom));
      default: put_text("loop");
    endcase
  endtask

  task automatic put_track(input int events);
    put(8'h00, 1'b1);       // track start with zero delta
    put(8'h90); put(8'h3C); put(8'h64);
    repeat (events) put_event();
    if ($urandom_range(2) != 0) begin
      put_delta(); put(ST_META); put(MC_END); put(8'h00);
      repeat ($urandom_range(3)) put(8'($urandom));   // ignored until next start
    end
  endtask

  task automatic drain_and_write(input logic [15:0] v);
    while (byte_q.size() > 0 || in_tvalid || event_q.size() > 0 || hold_left > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    tpq = v;
  endtask

  initial begin
    int sent;
    int q_before;
    int idle_in[5] = '{0, 68, 0, 31, 0};
    int idle_out[5] = '{0, 0, 68, 31, 0};
    logic [15:0] tpq_set[5] = '{16'd480, 16'hFFFF, 16'd0, 16'd96, 16'd0};
    rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = 0; out_tready = 1'b0;
    in_tvalid = 1'b0; in_tdata = 0; in_tuser = 0;
    reset_model();

    // Build the long loop keyword and its variants from the shared table.
    key_long = "";
    for (int i = 0; i < 19; i++) begin
      key_long = {key_long, " "};
      key_long.putc(i, kw_long(5'(i)));
    end
    key_upper = key_long.toupper();
    key_prefix = key_long.substr(0, 6);
    key_mixed = key_long;
    for (int i = 1; i < 19; i += 2) key_mixed.putc(i, key_upper[i]);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, pitch bend, wrapped sysex length, tempo, signatures.
    put(8'hFF, 1'b1); put(8'hFF); put(8'hFF); put(8'h7F);   // max 28-bit delta
    put(8'hE0); put(8'h00); put(8'h00);                      // bend low extreme
    put(8'h00); put(8'h7F); put(8'hFF);                      // running status, bit 7 data
    put(8'h00); put(8'hC5); put(8'h80);                      // program change
    put(8'h00); put(ST_SYSEX);
    put(8'h8F); put(8'hFF); put(8'hFF); put(8'hFF); put(8'h7F); // length wraps: no payload
    put(8'h00); put(ST_META); put(MC_TEMPO); put(8'h00);       // empty tempo body
    put(8'h00); put(ST_META); put(MC_TSIG); put(8'h04);
    put(8'hFF); put(8'h28); put(8'h18); put(8'h08);           // dd beyond 31
    put(8'h00); put(ST_META); put(MC_END); put(8'h00);
    put(8'h12);                                              // after end: dropped

    for (int ph = 0; ph < 5; ph++) begin
      drain_and_write(tpq_set[ph] == 16'd0 && ph == 4 ? 16'($urandom) : tpq_set[ph]);
      sender_idle_pct = idle_in[ph];
      receiver_stall_pct = idle_out[ph];
      if (ph == 4) hold_arm = 1'b1;   // long hold while the sender keeps offering
      sent = 0;
      while (sent < 280) begin
        q_before = byte_q.size();
        put_track($urandom_range(3, 12));
        sent += byte_q.size() - q_before;
        while (byte_q.size() > 40) @(posedge clk);
      end
    end

    while (byte_q.size() > 0 || in_tvalid || event_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
